// File: design/aalct_pkg.sv
// Shared types and constants for the ADC average / LED chaser / tick divider block.
package aalct_pkg;

   localparam int SampleBits         = 12;
   localparam int LedCount           = 8;
   localparam int WindowDepthDefault = 32;
   localparam int BlinkBits          = 4;

   // Terminal counts of the tick dividers
   localparam logic [6:0] SecondLast = 7'd99;
   localparam logic [3:0] Div10Last  = 4'd9;
   localparam logic [4:0] Div20Last  = 5'd19;
   localparam logic [6:0] Div100Last = 7'd99;
   localparam logic [2:0] Div5Last   = 3'd4;
   localparam logic [3:0] Div10bLast = 4'd9;

   localparam logic OpTick   = 1'b0;
   localparam logic OpSample = 1'b1;

   typedef logic [SampleBits-1:0] sample_type;
   typedef logic [LedCount-1:0]   led_type;
   typedef logic [BlinkBits-1:0]  blink_type;

   typedef struct packed {
      logic       op;
      sample_type sample;
   } req_type;

   typedef struct packed {
      sample_type avg_value;
      led_type    led_pattern;
      logic       led_update;
      logic       start_conversion;
      logic       pulse_base;
      logic       pulse_div10;
      logic       pulse_div20;
      logic       pulse_div100;
      logic       pulse_div500;
      logic       pulse_div1000;
      logic       pulse_second;
   } rsp_type;

   typedef struct packed {
      logic led_update;
      logic start_conversion;
      logic pulse_div10;
      logic pulse_div20;
      logic pulse_div100;
      logic pulse_div500;
      logic pulse_div1000;
      logic pulse_second;
   } tick_flags_type;

endpackage

// File: design/aalct_window_cell.sv
// One tap of the boxcar window: holds a sample and passes it to the next tap on a shift.
module aalct_window_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  aalct_pkg::sample_type  data_prev,
   output aalct_pkg::sample_type  data_out
);
   import aalct_pkg::*;

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = data_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

// File: design/aalct_avg_div.sv
// Divides the window sum by the window depth: a shift for powers of two, else a reciprocal multiply.
module aalct_avg_div #(
   parameter  int WINDOW_DEPTH = aalct_pkg::WindowDepthDefault,
   localparam int SumBits      = aalct_pkg::SampleBits + $clog2(WINDOW_DEPTH)
) (
   input  logic [SumBits-1:0]     sum_value,
   output aalct_pkg::sample_type  avg_value
);
   import aalct_pkg::*;

   localparam int DepthLog = $clog2(WINDOW_DEPTH);

   if ((WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0) begin : g_shift
      assign avg_value = sum_value[DepthLog +: SampleBits];
   end else begin : g_recip
      // floor(x / d) == (x * (floor(2^(n+l) / d) + 1)) >> (n+l) for every n-bit x
      localparam int          Shift     = SumBits + DepthLog;
      localparam int          RecipBits = SumBits + 1;
      localparam int          ProdBits  = SumBits + RecipBits;
      localparam logic [63:0] Recip     = ((64'd1 << Shift) / 64'(WINDOW_DEPTH)) + 64'd1;

      logic [ProdBits-1:0] product;

      assign product   = ProdBits'(sum_value) * ProdBits'(Recip[RecipBits-1:0]);
      assign avg_value = product[Shift +: SampleBits];
   end

endmodule

// File: design/aalct_tick_unit.sv
// Tick dividers, seconds counter and LED chaser; state advances on each accepted tick.
module aalct_tick_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  aalct_pkg::blink_type       limit,
   output aalct_pkg::tick_flags_type  flags,
   output aalct_pkg::led_type         led_next
);
   import aalct_pkg::*;

   logic [6:0] second_ff, second_in;
   blink_type  blink_ff, blink_in;
   led_type    led_ff, led_in;
   logic [3:0] div10_ff, div10_in;
   logic [4:0] div20_ff, div20_in;
   logic [6:0] div100_ff, div100_in;
   logic [2:0] div5_ff, div5_in;
   logic [3:0] div10b_ff, div10b_in;

   always_comb begin
      flags     = '0;
      second_in = second_ff;
      blink_in  = blink_ff;
      led_in    = led_ff;
      div10_in  = div10_ff;
      div20_in  = div20_ff;
      div100_in = div100_ff;
      div5_in   = div5_ff;
      div10b_in = div10b_ff;
      if (tick) begin
         flags.start_conversion = 1'b1;

         if (second_ff >= SecondLast) begin
            second_in          = '0;
            flags.pulse_second = 1'b1;
         end else begin
            second_in = second_ff + 7'd1;
         end

         // compare with >= so a falling average rotates on the next tick
         if (blink_ff >= limit) begin
            blink_in         = '0;
            led_in           = {led_ff[LedCount-2:0], led_ff[LedCount-1]};
            flags.led_update = 1'b1;
         end else begin
            blink_in = blink_ff + 1'b1;
         end

         if (div10_ff >= Div10Last) begin
            div10_in          = '0;
            flags.pulse_div10 = 1'b1;
         end else begin
            div10_in = div10_ff + 4'd1;
         end

         if (div20_ff >= Div20Last) begin
            div20_in          = '0;
            flags.pulse_div20 = 1'b1;
         end else begin
            div20_in = div20_ff + 5'd1;
         end

         if (div100_ff >= Div100Last) begin
            div100_in          = '0;
            flags.pulse_div100 = 1'b1;
            if (div5_ff >= Div5Last) begin
               div5_in            = '0;
               flags.pulse_div500 = 1'b1;
            end else begin
               div5_in = div5_ff + 3'd1;
            end
            if (div10b_ff >= Div10bLast) begin
               div10b_in           = '0;
               flags.pulse_div1000 = 1'b1;
            end else begin
               div10b_in = div10b_ff + 4'd1;
            end
         end else begin
            div100_in = div100_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= '0;
         blink_ff  <= '0;
         led_ff    <= led_type'(1);
         div10_ff  <= '0;
         div20_ff  <= '0;
         div100_ff <= '0;
         div5_ff   <= '0;
         div10b_ff <= '0;
      end else begin
         second_ff <= second_in;
         blink_ff  <= blink_in;
         led_ff    <= led_in;
         div10_ff  <= div10_in;
         div20_ff  <= div20_in;
         div100_ff <= div100_in;
         div5_ff   <= div5_in;
         div10b_ff <= div10b_in;
      end
   end

   assign led_next = led_in;

endmodule

// File: design/adc_average_led_chaser_ticker_unit.sv
// Boxcar average of converter samples plus tick dividers and an LED chaser. One request,
// a tick or a sample, is taken every cycle while the input does not stall; its result
// leaves through a capture stage and the output register. While a result waits, one more
// request fills the capture stage, and the input then stalls until the waiting result is
// taken. The window is a row of WINDOW_DEPTH sample taps that shift on every sample; the
// oldest tap leaves the running sum as the new sample enters it, and the average is that
// sum divided by the depth (a shift for powers of two, one multiply otherwise) on the way
// from the capture stage to the output register. The taps clear at reset.
module adc_average_led_chaser_ticker_unit #(
   parameter int WINDOW_DEPTH = aalct_pkg::WindowDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  aalct_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output aalct_pkg::rsp_type  rsp_data
);
   import aalct_pkg::*;

   localparam int SumBits = SampleBits + $clog2(WINDOW_DEPTH);

   sample_type     tap [WINDOW_DEPTH];
   logic           req_fire;
   logic           shift_en;
   logic           tick;
   logic [SumBits-1:0] sum_ff, sum_in;
   sample_type     avg_now;
   blink_type      limit;
   tick_flags_type flags;
   led_type        led_next;

   logic           a_valid_ff, a_valid_in;
   tick_flags_type a_flags_ff;
   led_type        a_led_ff;
   logic           a_move;
   logic           b_valid_ff, b_valid_in;
   logic           b_take;
   rsp_type        b_data_ff;

   // handshake
   assign b_take    = b_valid_ff & ~rsp_stall;
   assign a_move    = a_valid_ff & (~b_valid_ff | b_take);
   assign req_stall = a_valid_ff & ~a_move;
   assign req_fire  = req_valid & ~req_stall;
   assign shift_en  = req_fire & (req_data.op == OpSample);
   assign tick      = req_fire & (req_data.op == OpTick);

   // window taps
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_tap
      if (i == 0) begin : g_head
         aalct_window_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .data_prev (req_data.sample),
            .data_out  (tap[i])
         );
      end else begin : g_body
         aalct_window_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (shift_en),
            .data_prev (tap[i-1]),
            .data_out  (tap[i])
         );
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (shift_en) begin
         sum_in = sum_ff - SumBits'(tap[WINDOW_DEPTH-1]) + SumBits'(req_data.sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   aalct_avg_div #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_avg_div (
      .sum_value (sum_ff),
      .avg_value (avg_now)
   );

   assign limit = avg_now[SampleBits-1 -: BlinkBits];

   aalct_tick_unit u_tick (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .limit    (limit),
      .flags    (flags),
      .led_next (led_next)
   );

   assign a_valid_in = req_fire | (a_valid_ff & ~a_move);
   assign b_valid_in = a_move | (b_valid_ff & ~b_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_flags_ff <= flags;
         a_led_ff   <= led_next;
      end
   end

   // sum_ff holds still while the capture stage is full, so avg_now belongs to its request
   always_ff @(posedge clock) begin
      if (a_move) begin
         b_data_ff.avg_value        <= avg_now;
         b_data_ff.led_pattern      <= a_led_ff;
         b_data_ff.led_update       <= a_flags_ff.led_update;
         b_data_ff.start_conversion <= a_flags_ff.start_conversion;
         b_data_ff.pulse_base       <= 1'b1;
         b_data_ff.pulse_div10      <= a_flags_ff.pulse_div10;
         b_data_ff.pulse_div20      <= a_flags_ff.pulse_div20;
         b_data_ff.pulse_div100     <= a_flags_ff.pulse_div100;
         b_data_ff.pulse_div500     <= a_flags_ff.pulse_div500;
         b_data_ff.pulse_div1000    <= a_flags_ff.pulse_div1000;
         b_data_ff.pulse_second     <= a_flags_ff.pulse_second;
      end
   end

   assign rsp_valid = b_valid_ff;
   assign rsp_data  = b_data_ff;

endmodule
